### rtl/core/edd_pkg.sv
`timescale 1ns / 1ps

package edd_pkg;

   localparam int CHANNELS = 3;

   // csr width register
   localparam int CSR_BITS    = 13;
   localparam int WIDTH_RESET = 640;

   // fixed point scale: pixel * 16
   localparam int PIXEL_SHIFT = 4;
   localparam int FULL_SCALE  = 4080;
   localparam int THRESHOLD   = 2040;

   // diffusion weights, in sixteenths
   localparam int SHARE_RIGHT      = 7;
   localparam int SHARE_DOWN_LEFT  = 3;
   localparam int SHARE_DOWN       = 5;
   localparam int SHARE_DOWN_RIGHT = 1;
   localparam int SHARE_SHIFT      = 4;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic red_on;
      logic green_on;
      logic blue_on;
   } rsp_type;

endpackage

### rtl/core/edd_ram.sv
`timescale 1ns / 1ps

module edd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/error_diffusion_dither.sv
`timescale 1ns / 1ps
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  edd_pkg::req_type (pixel, frame_start)
// rsp      out        rsp_valid/rsp_stall  edd_pkg::rsp_type (three dithered bits)
// csr      in         csr_wr_en            csr_wr_data = image_width
//
// One item per cycle sustained while rsp is not stalled. rsp_valid rises when
// the item leaves the input stage: the row buffer read is issued at accept,
// the pixel is dithered there and the bits land in the output register.
// Synchronous reset clears handshake, carries, column, loads width, sets first_row;
// the row buffer is not cleared (entries are written during the first row).
// A stalled rsp holds the item in the input stage, which then stalls req.

module error_diffusion_dither #(
   parameter int MAX_WIDTH  = 4096,
   parameter int ERROR_BITS = 14
) (
   input  logic                           clock,
   input  logic                           reset,
   // pixel input
   input  logic                           req_valid,
   output logic                           req_stall,
   input  edd_pkg::req_type               req_data,
   // dithered output
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output edd_pkg::rsp_type               rsp_data,
   // image width register
   input  logic                           csr_wr_en,
   input  logic [edd_pkg::CSR_BITS-1:0]   csr_wr_data
);

   localparam int CH = edd_pkg::CHANNELS;
   localparam int AW = $clog2(MAX_WIDTH);
   // width compare needs room for the register and for MAX_WIDTH itself
   localparam int LW = (AW + 1 > edd_pkg::CSR_BITS) ? AW + 1 : edd_pkg::CSR_BITS;
   // working value: pixel*16 plus two error terms
   localparam int VW = ((ERROR_BITS > 13) ? ERROR_BITS : 13) + 2;
   // room for err*7 and a following add
   localparam int SW = VW + 4;
   localparam int DW = CH * ERROR_BITS;

   localparam logic signed [SW-1:0] ERR_HI = SW'((1 << (ERROR_BITS - 1)) - 1);
   localparam logic signed [SW-1:0] ERR_LO = SW'(-(1 << (ERROR_BITS - 1)));
   localparam logic signed [SW-1:0] FULL   = SW'(edd_pkg::FULL_SCALE);
   localparam logic signed [SW-1:0] THRESH = SW'(edd_pkg::THRESHOLD);
   localparam logic signed [SW-1:0] K_R    = SW'(edd_pkg::SHARE_RIGHT);
   localparam logic signed [SW-1:0] K_DL   = SW'(edd_pkg::SHARE_DOWN_LEFT);
   localparam logic signed [SW-1:0] K_D    = SW'(edd_pkg::SHARE_DOWN);
   localparam logic signed [SW-1:0] K_DR   = SW'(edd_pkg::SHARE_DOWN_RIGHT);

   function automatic logic signed [ERROR_BITS-1:0] sat_err(input logic signed [SW-1:0] v);
      if (v > ERR_HI) begin
         return ERR_HI[ERROR_BITS-1:0];
      end else if (v < ERR_LO) begin
         return ERR_LO[ERROR_BITS-1:0];
      end
      return v[ERROR_BITS-1:0];
   endfunction

   // ---------------------------------------------------------------- registers
   logic [edd_pkg::CSR_BITS-1:0]   width_ff;

   logic                           p_valid_ff, p_valid_in;
   edd_pkg::req_type               p_data_ff;
   logic [AW-1:0]                  x_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   edd_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic [AW-1:0]                  col_ff, col_in;
   logic                           first_row_ff, first_row_in;

   logic signed [ERROR_BITS-1:0]   rc_ff [CH];
   logic signed [ERROR_BITS-1:0]   pl_ff [CH];
   logic signed [ERROR_BITS-1:0]   ph_ff [CH];
   logic signed [ERROR_BITS-1:0]   rc_in [CH];
   logic signed [ERROR_BITS-1:0]   pl_in [CH];
   logic signed [ERROR_BITS-1:0]   ph_in [CH];

   // down share of the last column, written in the following cycle
   logic                           pend_valid_ff, pend_valid_in;
   logic [AW-1:0]                  pend_addr_ff;
   logic [DW-1:0]                  pend_data_ff, pend_data_in;

   // row buffer writes that landed at or after the read of the waiting item
   logic                           byp_hit_ff;
   logic [DW-1:0]                  byp_data_ff;

   // ---------------------------------------------------------------- control
   logic                           adv, accept, last, fs, first_row_eff;
   logic [LW-1:0]                  width_l, width_lm1;
   logic [AW-1:0]                  wlast, col_src, rd_addr;

   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   logic [DW-1:0]                  wr_data, down_word, ram_q, fwd_word;
   logic                           pend_write;

   assign adv       = p_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = p_valid_ff && !adv;
   assign accept    = req_valid && !req_stall;

   // effective width: zero acts as one, large values clip at MAX_WIDTH
   always_comb begin
      width_l = LW'(width_ff);
      if (width_l == '0) begin
         width_l = LW'(1);
      end else if (width_l > LW'(MAX_WIDTH)) begin
         width_l = LW'(MAX_WIDTH);
      end
      width_lm1 = width_l - LW'(1);
   end
   assign wlast = width_lm1[AW-1:0];

   assign last          = (x_ff == wlast);
   assign fs            = p_data_ff.frame_start;
   assign first_row_eff = fs || first_row_ff;

   // column of the item arriving now, after the one leaving this cycle
   assign col_src = adv ? col_in : col_ff;
   assign rd_addr = req_data.frame_start ? '0 : ((col_src > wlast) ? wlast : col_src);

   // newest copy of the entry above the current pixel
   always_comb begin
      if (pend_valid_ff && (pend_addr_ff == x_ff)) begin
         fwd_word = pend_data_ff;
      end else if (byp_hit_ff) begin
         fwd_word = byp_data_ff;
      end else begin
         fwd_word = ram_q;
      end
   end

   // ---------------------------------------------------------------- datapath
   logic [7:0]                     pix   [CH];
   logic signed [ERROR_BITS-1:0]   above [CH];
   logic signed [ERROR_BITS-1:0]   rc_eff [CH];
   logic signed [ERROR_BITS-1:0]   pl_eff [CH];
   logic signed [ERROR_BITS-1:0]   ph_eff [CH];
   logic signed [SW-1:0]           v_w   [CH];
   logic signed [SW-1:0]           err_w [CH];
   logic signed [SW-1:0]           s_r   [CH];
   logic signed [SW-1:0]           s_dl  [CH];
   logic signed [SW-1:0]           s_d   [CH];
   logic signed [SW-1:0]           s_dr  [CH];
   logic                           on_w  [CH];

   assign pix[0] = p_data_ff.red_in;
   assign pix[1] = p_data_ff.green_in;
   assign pix[2] = p_data_ff.blue_in;

   always_comb begin
      for (int c = 0; c < CH; c++) begin
         above[c]  = first_row_eff ? '0 : $signed(fwd_word[c*ERROR_BITS +: ERROR_BITS]);
         rc_eff[c] = fs ? '0 : rc_ff[c];
         pl_eff[c] = fs ? '0 : pl_ff[c];
         ph_eff[c] = fs ? '0 : ph_ff[c];

         v_w[c]   = SW'($signed({1'b0, pix[c], {edd_pkg::PIXEL_SHIFT{1'b0}}}))
                    + SW'(rc_eff[c]) + SW'(above[c]);
         on_w[c]  = v_w[c] > THRESH;
         err_w[c] = on_w[c] ? (v_w[c] - FULL) : v_w[c];

         // floor division by 16 via arithmetic shift
         s_r[c]  = (err_w[c] * K_R)  >>> edd_pkg::SHARE_SHIFT;
         s_dl[c] = (err_w[c] * K_DL) >>> edd_pkg::SHARE_SHIFT;
         s_d[c]  = (err_w[c] * K_D)  >>> edd_pkg::SHARE_SHIFT;
         s_dr[c] = (err_w[c] * K_DR) >>> edd_pkg::SHARE_SHIFT;

         down_word[c*ERROR_BITS +: ERROR_BITS] = sat_err(SW'(pl_eff[c]) + s_dl[c]);
         pend_data_in[c*ERROR_BITS +: ERROR_BITS] = sat_err(SW'(ph_eff[c]) + s_d[c]);

         // row end clears every carry
         pl_in[c] = last ? '0 : sat_err(SW'(ph_eff[c]) + s_d[c]);
         ph_in[c] = last ? '0 : sat_err(s_dr[c]);
         rc_in[c] = last ? '0 : sat_err(s_r[c]);
      end
   end

   assign rsp_data_in.red_on   = on_w[0];
   assign rsp_data_in.green_on = on_w[1];
   assign rsp_data_in.blue_on  = on_w[2];

   assign col_in       = last ? '0 : (x_ff + AW'(1));
   assign first_row_in = last ? 1'b0 : first_row_eff;

   // ---------------------------------------------------------------- row buffer
   // Column x writes x-1; the column after a row end is column 0 and writes
   // nothing, which leaves the port free for the pending last-column entry.
   always_comb begin
      pend_write = 1'b0;
      if (adv && (x_ff != '0)) begin
         wr_en   = 1'b1;
         wr_addr = x_ff - AW'(1);
         wr_data = down_word;
      end else begin
         wr_en      = pend_valid_ff;
         pend_write = pend_valid_ff;
         wr_addr    = pend_addr_ff;
         wr_data    = pend_data_ff;
      end
   end

   assign pend_valid_in = (adv && last) ? 1'b1 : (pend_write ? 1'b0 : pend_valid_ff);

   edd_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_WIDTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // ---------------------------------------------------------------- handshake
   always_comb begin
      if (accept) begin
         p_valid_in = 1'b1;
      end else if (adv) begin
         p_valid_in = 1'b0;
      end else begin
         p_valid_in = p_valid_ff;
      end
   end

   always_comb begin
      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= edd_pkg::CSR_BITS'(edd_pkg::WIDTH_RESET);
         p_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         byp_hit_ff    <= 1'b0;
         col_ff        <= '0;
         first_row_ff  <= 1'b1;
         for (int c = 0; c < CH; c++) begin
            rc_ff[c] <= '0;
            pl_ff[c] <= '0;
            ph_ff[c] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            width_ff <= csr_wr_data;
         end
         p_valid_ff    <= p_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         if (accept) begin
            byp_hit_ff <= wr_en && (wr_addr == rd_addr);
         end else if (wr_en && (wr_addr == x_ff)) begin
            byp_hit_ff <= 1'b1;
         end
         if (adv) begin
            col_ff       <= col_in;
            first_row_ff <= first_row_in;
            for (int c = 0; c < CH; c++) begin
               rc_ff[c] <= rc_in[c];
               pl_ff[c] <= pl_in[c];
               ph_ff[c] <= ph_in[c];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         p_data_ff <= req_data;
         x_ff      <= rd_addr;
      end
      if (accept || (wr_en && (wr_addr == x_ff))) begin
         byp_data_ff <= wr_data;
      end
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (adv && last) begin
         pend_addr_ff <= x_ff;
         pend_data_ff <= pend_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   // the pending entry never competes with a column write for the port
   a_pend_port: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> !(adv && (x_ff != '0)))
      else $error("pending row entry collides with a column write");

   // a pending entry drains in the next cycle unless a new row end refills it
   a_pend_drain: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && !(adv && last)) |=> !pend_valid_ff)
      else $error("pending row entry not drained");

   // a row end restarts the column
   a_row_end: assert property (@(posedge clock) disable iff (reset)
      (adv && last) |=> (col_ff == '0))
      else $error("column not cleared at row end");

   // a result appears only after an item left the input stage
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(p_valid_ff))
      else $error("result without an item in the input stage");

endmodule

### sim/edd_check_pkg.sv
`timescale 1ns / 1ps

package edd_check_pkg;

   import edd_pkg::*;

   localparam int ROW_DEPTH  = 4096;
   localparam int ERR_BITS   = 14;
   localparam int ERR_MAX    = (1 << (ERR_BITS - 1)) - 1;
   localparam int ERR_MIN    = -ERR_MAX - 1;
   localparam int REPORT_CAP = 10;

   class dither_scoreboard;

      // predictor state, per channel
      int          row_error [CHANNELS][ROW_DEPTH];
      int          carry_right [CHANNELS];
      int          pend_left [CHANNELS];
      int          pend_here [CHANNELS];
      int unsigned column;
      bit          in_first_row;
      logic [CSR_BITS-1:0] width_reg;

      rsp_type     expected_bits [$];

      int          mismatches;
      int          strays;
      int          results_checked;
      int          rows_done;

      function new();
         foreach (row_error[c, x]) row_error[c][x] = 0;
         clear_carries();
         in_first_row    = 1'b1;
         width_reg       = CSR_BITS'(WIDTH_RESET);
         mismatches      = 0;
         strays          = 0;
         results_checked = 0;
         rows_done       = 0;
      endfunction

      function void clear_carries();
         foreach (carry_right[c]) begin
            carry_right[c] = 0;
            pend_left[c]   = 0;
            pend_here[c]   = 0;
         end
         column = 0;
      endfunction

      function void set_width(logic [CSR_BITS-1:0] w);
         width_reg = w;
      endfunction

      function int pending();
         return expected_bits.size();
      endfunction

      function int clip_error(int v);
         if (v > ERR_MAX) return ERR_MAX;
         if (v < ERR_MIN) return ERR_MIN;
         return v;
      endfunction

      // floor(err * k / 16)
      function int share(int err, int k);
         return (err * k) >>> SHARE_SHIFT;
      endfunction

      function void add_pixel(req_type px);
         int unsigned w;
         int unsigned x;
         bit          last;
         int          pix [CHANNELS];
         bit          on [CHANNELS];
         int          above;
         int          v;
         int          err;
         rsp_type     res;

         w = (width_reg == 0) ? 1 : ((width_reg > ROW_DEPTH) ? ROW_DEPTH : width_reg);
         if (px.frame_start) begin
            clear_carries();
            in_first_row = 1'b1;
         end
         x = (column > w - 1) ? w - 1 : column;
         last = (x == w - 1);
         pix[0] = px.red_in;
         pix[1] = px.green_in;
         pix[2] = px.blue_in;

         for (int c = 0; c < CHANNELS; c++) begin
            above = in_first_row ? 0 : row_error[c][x];
            v     = (pix[c] << PIXEL_SHIFT) + carry_right[c] + above;
            on[c] = (v > THRESHOLD);
            err   = on[c] ? v - FULL_SCALE : v;
            if (x >= 1)
               row_error[c][x-1] = clip_error(pend_left[c] + share(err, SHARE_DOWN_LEFT));
            pend_left[c] = clip_error(pend_here[c] + share(err, SHARE_DOWN));
            if (last) begin
               row_error[c][x] = pend_left[c];
            end else begin
               pend_here[c]   = clip_error(share(err, SHARE_DOWN_RIGHT));
               carry_right[c] = clip_error(share(err, SHARE_RIGHT));
            end
         end

         if (last) begin
            clear_carries();
            in_first_row = 1'b0;
            rows_done++;
         end else begin
            column = x + 1;
         end

         res.red_on   = on[0];
         res.green_on = on[1];
         res.blue_on  = on[2];
         expected_bits = {expected_bits, res};
      endfunction

      function void check_bits(rsp_type got);
         rsp_type want;
         if (expected_bits.size() == 0) begin
            strays++;
            if (strays + mismatches <= REPORT_CAP)
               $display("unexpected result r%b g%b b%b with nothing pending",
                        got.red_on, got.green_on, got.blue_on);
            return;
         end
         want = expected_bits.pop_front();
         results_checked++;
         if (got.red_on !== want.red_on || got.green_on !== want.green_on ||
             got.blue_on !== want.blue_on) begin
            mismatches++;
            if (strays + mismatches <= REPORT_CAP)
               $display("result %0d: expected r%b g%b b%b, got r%b g%b b%b",
                        results_checked, want.red_on, want.green_on, want.blue_on,
                        got.red_on, got.green_on, got.blue_on);
         end
      endfunction

   endclass

endpackage

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   import edd_pkg::*;
   import edd_check_pkg::*;

   localparam int CYCLE_LIMIT = 600000;  // well above the slowest legal run
   localparam int SETTLE      = 4;       // pipeline is two deep

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_type             rsp_data;
   logic                csr_wr_en;
   logic [CSR_BITS-1:0] csr_wr_data;

   dither_scoreboard sb;

   // percent knobs for idle bursts, drawn per item for req and per cycle for rsp
   int req_idle_pct;
   int rsp_idle_pct;
   int pixels_sent;
   int widths_tried;
   int failures;

   error_diffusion_dither u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // timeout guard
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("error_diffusion_dither test failed");
      $finish;
   end

   // Receiver: stalls come in random bursts. One assignment per
   // falling edge, so a held stall is never dropped and raised in one step.
   initial begin
      int hold;
      hold      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (rsp_idle_pct > 0 && $urandom_range(1, 100) <= rsp_idle_pct) begin
            rsp_stall <= 1'b1;
            hold = $urandom_range(1, 10) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every accepted result is checked against the oldest pending item.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_bits(rsp_data);
   end

   function automatic req_type pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic fs);
      req_type p;
      p.red_in      = r;
      p.green_in    = g;
      p.blue_in     = b;
      p.frame_start = fs;
      return p;
   endfunction

   // skewed toward the rails and the threshold (127 -> 2032, 128 -> 2048)
   function automatic logic [7:0] rand_channel();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'($urandom_range(120, 135));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // All driving tasks start and end on a falling edge.
   task automatic send_item(req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sb.add_pixel(item);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic idle_sender(int n);
      req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // hold off input until every pending result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // width is only changed with the pipe empty; a frame always follows
   task automatic set_width(logic [CSR_BITS-1:0] w);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      sb.set_width(w);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      widths_tried++;
   endtask

   // One frame per phase start, plus occasional frame starts at random positions.
   task automatic run_random_phase(logic [CSR_BITS-1:0] w, int count, int req_pct,
                                   int rsp_pct, bit pause_midway);
      req_type item;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      set_width(w);
      for (int i = 0; i < count; i++) begin
         if (pause_midway && i == count / 2)
            drain_results();
         if (req_idle_pct > 0 && $urandom_range(1, 100) <= req_idle_pct)
            idle_sender($urandom_range(1, 10));
         item = pixel(rand_channel(), rand_channel(), rand_channel(),
                      (i == 0) || ($urandom_range(0, 63) == 0));
         send_item(item);
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      pixels_sent  = 0;
      widths_tried = 0;
      sb           = new();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset width, rails, threshold edges, bit patterns,
      // frame start in mid-row and back to back.
      send_item(pixel(8'd0,   8'd0,   8'd0,   1'b1));
      send_item(pixel(8'd255, 8'd255, 8'd255, 1'b0));
      send_item(pixel(8'd128, 8'd127, 8'd128, 1'b0));
      send_item(pixel(8'd127, 8'd128, 8'd127, 1'b0));
      send_item(pixel(8'h55,  8'hAA,  8'h55,  1'b0));
      send_item(pixel(8'hAA,  8'h55,  8'hAA,  1'b0));
      send_item(pixel(8'd200, 8'd100, 8'd50,  1'b1));
      send_item(pixel(8'd128, 8'd128, 8'd128, 1'b1));
      send_item(pixel(8'd1,   8'd254, 8'd128, 1'b0));

      // width 1: every pixel is the last column of its row
      set_width(13'd1);
      send_item(pixel(8'd255, 8'd0,   8'd128, 1'b1));
      send_item(pixel(8'd0,   8'd255, 8'd127, 1'b0));
      send_item(pixel(8'd128, 8'd128, 8'd128, 1'b0));
      send_item(pixel(8'd127, 8'd127, 8'd127, 1'b0));
      send_item(pixel(8'd255, 8'd255, 8'd255, 1'b0));

      // width 3: rails held across rows to push the error sums around
      set_width(13'd3);
      send_item(pixel(8'd255, 8'd0,   8'd127, 1'b1));
      send_item(pixel(8'd255, 8'd0,   8'd127, 1'b0));
      send_item(pixel(8'd255, 8'd0,   8'd127, 1'b0));
      send_item(pixel(8'd0,   8'd255, 8'd128, 1'b0));
      send_item(pixel(8'd0,   8'd255, 8'd128, 1'b0));
      send_item(pixel(8'd0,   8'd255, 8'd128, 1'b0));
      send_item(pixel(8'd128, 8'd128, 8'd0,   1'b0));

      // Random phases; width 0 acts as 1, widths past the row buffer clamp.
      run_random_phase(13'd0,    60,   30, 30, 1'b0);
      run_random_phase(13'd2,    120,  10, 50, 1'b0);
      run_random_phase(13'd3,    150,  50, 10, 1'b0);
      run_random_phase(13'd5,    150,  0,  30, 1'b0);
      run_random_phase(13'd16,   150,  30, 0,  1'b0);
      run_random_phase(13'd37,   150,  20, 20, 1'b0);
      run_random_phase(13'd4096, 40,   20, 20, 1'b0);
      // widest setting clamps to the row buffer depth
      run_random_phase(13'd8191, 40,   5,  5,  1'b0);
      run_random_phase(13'd5000, 30,   30, 30, 1'b0);
      run_random_phase(13'd1,    60,   20, 40, 1'b0);
      run_random_phase(13'd7,    150,  40, 40, 1'b0);
      run_random_phase(13'd100,  200,  15, 15, 1'b1);
      run_random_phase(13'd640,  100,  10, 10, 1'b0);

      // closing stretch at full rate, no idling anywhere
      run_random_phase(13'd13,   150,  0,  0,  1'b0);
      run_random_phase(13'd64,   150,  0,  0,  1'b0);

      drain_results();
      repeat (10) @(negedge clock);

      failures = sb.mismatches + sb.strays + sb.pending();
      $display("covered %0d pixels over %0d width settings (0, 1, 4096 and above), %0d rows",
               pixels_sent, widths_tried, sb.rows_done);
      $display("%0d results compared, %0d mismatches, %0d unexpected, %0d missing",
               sb.results_checked, sb.mismatches, sb.strays, sb.pending());
      if (failures == 0) begin
         $display("error_diffusion_dither test passed");
      end else begin
         $display("error_diffusion_dither test failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/edd_pkg.sv
rtl/core/edd_ram.sv
rtl/core/error_diffusion_dither.sv
sim/edd_check_pkg.sv
sim/testbench.sv
